/* hdl/lrcf_pkg.sv */
// ---------------------------------------------------------------------------
// lrcf_pkg
// shared types and constants of the panel fill sequencer
// ---------------------------------------------------------------------------
package lrcf_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned RADIUS_W = 7;

  localparam logic [RADIUS_W-1:0] MAX_RADIUS_RST = 7'd127;

  // request codes
  localparam logic [1:0] FUNC_RECT = 2'd0;
  localparam logic [1:0] FUNC_CIRC = 2'd1;
  localparam logic [1:0] FUNC_ADV  = 2'd2;

  // panel commands
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  typedef enum logic [1:0] {
    JOB_IDLE = 2'd0,
    JOB_RECT = 2'd1,
    JOB_CIRC = 2'd2
  } job_t;

  typedef struct packed {
    logic                start;
    logic [RADIUS_W-1:0] radius;
    logic [RADIUS_W-1:0] row;
  } root_req_t;

  typedef struct packed {
    logic                done;
    logic [RADIUS_W-1:0] half_width;
  } root_sts_t;

endpackage

/* hdl/lrcf_if.sv */
// ---------------------------------------------------------------------------
// lrcf_in_if / lrcf_out_if
// valid/ready channels of the panel fill sequencer
// ---------------------------------------------------------------------------
interface lrcf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  rect_width;
  logic [7:0]  rect_height;
  logic [6:0]  radius;
  logic [15:0] fill_color;

  modport source (
    output valid, func, pos_x, pos_y, rect_width, rect_height, radius, fill_color,
    input  ready
  );
  modport sink (
    input  valid, func, pos_x, pos_y, rect_width, rect_height, radius, fill_color,
    output ready
  );
endinterface

interface lrcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (
    output valid, out_byte, is_data, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, is_data, last,
    output ready
  );
endinterface

/* hdl/lrcf_root_unit.sv */
// ---------------------------------------------------------------------------
// lrcf_root_unit
// span half width of one circle row: largest c with (5c-2)^2 <= 25(r^2-i^2),
// found bit by bit over one shared multiplier
// ---------------------------------------------------------------------------
module lrcf_root_unit
  import lrcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  root_req_t req,
  output root_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROD,
    S_SCALE,
    S_SRCH
  } state_t;

  state_t              st_r, st_nxt;
  logic [14:0]         p_r, p_nxt;
  logic [18:0]         d_r, d_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic [RADIUS_W-1:0] c_r, c_nxt;
  logic                done_r, done_nxt;

  logic [9:0]          mul_a, mul_b;
  logic [19:0]         prod;
  logic [RADIUS_W-1:0] c_try;
  logic [9:0]          t;

  assign prod  = mul_a * mul_b;
  assign c_try = c_r | (RADIUS_W'(1) << bit_r);
  assign t     = {1'b0, c_try, 2'b00} + {3'b000, c_try} - 10'd2;

  always_comb begin
    st_nxt   = st_r;
    p_nxt    = p_r;
    d_nxt    = d_r;
    bit_nxt  = bit_r;
    c_nxt    = c_r;
    done_nxt = 1'b0;
    mul_a    = t;
    mul_b    = t;
    unique case (st_r)
      S_IDLE: begin
        if (req.start) begin
          st_nxt = S_PROD;
        end
      end
      S_PROD: begin
        mul_a  = 10'({1'b0, req.radius} + {1'b0, req.row});
        mul_b  = 10'(req.radius - req.row);
        p_nxt  = prod[14:0];
        st_nxt = S_SCALE;
      end
      S_SCALE: begin
        d_nxt   = {p_r, 4'b0000} + {1'b0, p_r, 3'b000} + {4'b0000, p_r};
        bit_nxt = 3'd6;
        c_nxt   = '0;
        st_nxt  = S_SRCH;
      end
      S_SRCH: begin
        if (prod <= {1'b0, d_r}) begin
          c_nxt = c_try;
        end
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          done_nxt = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      bit_r  <= '0;
      c_r    <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      bit_r  <= bit_nxt;
      c_r    <= c_nxt;
    end
    p_r <= p_nxt;
    d_r <= d_nxt;
  end

  assign sts.done       = done_r;
  assign sts.half_width = c_r;

endmodule

/* hdl/lcd_rect_circle_fill_sequencer_core.sv */
// ---------------------------------------------------------------------------
// lcd_rect_circle_fill_sequencer_core
// panel byte sequencer for rectangle and filled-circle fills
// ---------------------------------------------------------------------------
// in_chan carries requests: a rectangle or circle start, if idle, latches its
// operands, returns nothing; an advance in a fill returns one panel byte on
// out_chan with its command/data flag and a last flag on the final byte.
// every window opens with 0x2A and the column pair, 0x2B and the row pair,
// then 0x2C, followed by RGB565 pixels sent high byte first.
// cfg_we/cfg_wdata write max_radius; larger or zero radii are dropped.
// a byte shows on out_chan in the cycle after its advance request is taken;
// while the receiver keeps up, one request per cycle is accepted.
// each circle row needs its span half width from the root unit (one multiply,
// one scale, seven search steps on one multiplier); while it is worked out,
// after a circle start and after the last byte of each row's lower span but
// the last row's, in_chan.ready is low.
// when out_chan stalls, the held byte stays and in_chan.ready drops.
// reset (rst_n low, synchronous) leaves the block idle, max_radius at 127.
// ---------------------------------------------------------------------------
module lcd_rect_circle_fill_sequencer_core
  import lrcf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  lrcf_in_if.sink             in_chan,
  lrcf_out_if.source          out_chan,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_wdata
);

  localparam logic [3:0] PH_CASET  = 4'd0;
  localparam logic [3:0] PH_XS_HI  = 4'd1;
  localparam logic [3:0] PH_XS_LO  = 4'd2;
  localparam logic [3:0] PH_XE_HI  = 4'd3;
  localparam logic [3:0] PH_XE_LO  = 4'd4;
  localparam logic [3:0] PH_RASET  = 4'd5;
  localparam logic [3:0] PH_YS_HI  = 4'd6;
  localparam logic [3:0] PH_YS_LO  = 4'd7;
  localparam logic [3:0] PH_YE_HI  = 4'd8;
  localparam logic [3:0] PH_YE_LO  = 4'd9;
  localparam logic [3:0] PH_RAMWR  = 4'd10;
  localparam logic [3:0] PH_PIXELS = 4'd11;

  typedef enum logic {
    S_RUN,
    S_ROOT
  } state_t;

  state_t              state_r, state_nxt;
  job_t                job_r, job_nxt;
  logic [3:0]          phase_r, phase_nxt;
  logic [RADIUS_W-1:0] row_r, row_nxt;
  logic                lower_r, lower_nxt;
  logic [RADIUS_W-1:0] hw_r, hw_nxt;
  logic [COORD_W-1:0]  pix_r, pix_nxt;
  logic                lowb_r, lowb_nxt;
  logic [7:0]          x_r, x_nxt;
  logic [7:0]          y_r, y_nxt;
  logic [7:0]          w_r, w_nxt;
  logic [7:0]          h_r, h_nxt;
  logic [RADIUS_W-1:0] r_r, r_nxt;
  logic [15:0]         color_r, color_nxt;
  logic [RADIUS_W-1:0] max_r_r, max_r_nxt;
  logic                root_start_r, root_start_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_ready, in_acc, out_acc;
  logic                win_done;
  logic [COORD_W-1:0]  wx, wy, ww, wh, c1, c2, r2, pix_dec, span_pix;
  logic [RADIUS_W-1:0] row_inc;
  root_req_t           root_req;
  root_sts_t           root_sts;

  assign root_req.start  = root_start_r;
  assign root_req.radius = r_r;
  assign root_req.row    = row_r;

  lrcf_root_unit u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .sts   (root_sts)
  );

  assign in_ready = (state_r == S_RUN) && (!out_valid_r || out_chan.ready);
  assign in_acc   = in_chan.valid && in_ready;
  assign out_acc  = out_valid_r && out_chan.ready;

  assign wx = (job_r == JOB_RECT) ? {8'h00, x_r}
                                  : {8'h00, x_r} - {9'h000, hw_r};
  assign wy = (job_r == JOB_RECT) ? {8'h00, y_r}
            : lower_r ? {8'h00, y_r} + {9'h000, row_r}
                      : {8'h00, y_r} - {9'h000, row_r};
  assign ww = (job_r == JOB_RECT) ? {8'h00, w_r} : {8'h00, hw_r, 1'b0};
  assign wh = (job_r == JOB_RECT) ? {8'h00, h_r} : 16'd1;
  assign c1 = wx + 16'd1;
  assign c2 = wx + ww;
  assign r2 = wy + wh;

  assign pix_dec  = pix_r - 16'd1;
  assign row_inc  = row_r + RADIUS_W'(1);
  assign span_pix = {8'h00, hw_r, 1'b0};

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    phase_nxt      = phase_r;
    row_nxt        = row_r;
    lower_nxt      = lower_r;
    hw_nxt         = hw_r;
    pix_nxt        = pix_r;
    lowb_nxt       = lowb_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    r_nxt          = r_r;
    color_nxt      = color_r;
    max_r_nxt      = cfg_we ? cfg_wdata : max_r_r;
    root_start_nxt = 1'b0;
    out_valid_nxt  = out_valid_r && !out_acc;
    out_byte_nxt   = out_byte_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    win_done       = 1'b0;

    if (state_r == S_ROOT && root_sts.done) begin
      hw_nxt    = root_sts.half_width;
      lower_nxt = 1'b0;
      phase_nxt = PH_CASET;
      lowb_nxt  = 1'b0;
      pix_nxt   = {8'h00, root_sts.half_width, 1'b0};
      state_nxt = S_RUN;
    end

    if (in_acc) begin
      unique case (in_chan.func)
        FUNC_RECT, FUNC_CIRC: begin
          if (job_r == JOB_IDLE) begin
            x_nxt     = in_chan.pos_x;
            y_nxt     = in_chan.pos_y;
            color_nxt = in_chan.fill_color;
            if (in_chan.func == FUNC_RECT) begin
              w_nxt     = in_chan.rect_width;
              h_nxt     = in_chan.rect_height;
              job_nxt   = JOB_RECT;
              phase_nxt = PH_CASET;
              lowb_nxt  = 1'b0;
              pix_nxt   = {8'h00, in_chan.rect_width} * {8'h00, in_chan.rect_height};
            end else if (in_chan.radius != '0 && in_chan.radius <= max_r_r) begin
              r_nxt          = in_chan.radius;
              job_nxt        = JOB_CIRC;
              row_nxt        = '0;
              state_nxt      = S_ROOT;
              root_start_nxt = 1'b1;
            end
          end
        end
        FUNC_ADV: begin
          if (job_r != JOB_IDLE) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = 1'b1;
            out_last_nxt  = 1'b0;
            if (phase_r < PH_PIXELS) begin
              phase_nxt = phase_r + 4'd1;
              unique case (phase_r)
                PH_CASET: begin
                  out_byte_nxt = CMD_CASET;
                  out_data_nxt = 1'b0;
                end
                PH_XS_HI: out_byte_nxt = c1[15:8];
                PH_XS_LO: out_byte_nxt = c1[7:0];
                PH_XE_HI: out_byte_nxt = c2[15:8];
                PH_XE_LO: out_byte_nxt = c2[7:0];
                PH_RASET: begin
                  out_byte_nxt = CMD_RASET;
                  out_data_nxt = 1'b0;
                end
                PH_YS_HI: out_byte_nxt = wy[15:8];
                PH_YS_LO: out_byte_nxt = wy[7:0];
                PH_YE_HI: out_byte_nxt = r2[15:8];
                PH_YE_LO: out_byte_nxt = r2[7:0];
                default: begin
                  out_byte_nxt = CMD_RAMWR;
                  out_data_nxt = 1'b0;
                end
              endcase
              if (phase_r == PH_RAMWR && pix_r == '0) begin
                win_done = 1'b1;
              end
            end else if (!lowb_r) begin
              out_byte_nxt = color_r[15:8];
              lowb_nxt     = 1'b1;
            end else begin
              out_byte_nxt = color_r[7:0];
              lowb_nxt     = 1'b0;
              pix_nxt      = pix_dec;
              if (pix_dec == '0) begin
                win_done = 1'b1;
              end
            end

            if (win_done) begin
              priority if (job_r == JOB_CIRC && !lower_r) begin
                lower_nxt = 1'b1;
                phase_nxt = PH_CASET;
                lowb_nxt  = 1'b0;
                pix_nxt   = span_pix;
              end else if (job_r == JOB_CIRC && row_inc < r_r) begin
                row_nxt        = row_inc;
                state_nxt      = S_ROOT;
                root_start_nxt = 1'b1;
              end else begin
                job_nxt      = JOB_IDLE;
                phase_nxt    = PH_CASET;
                out_last_nxt = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_RUN;
      job_r        <= JOB_IDLE;
      phase_r      <= PH_CASET;
      row_r        <= '0;
      lower_r      <= 1'b0;
      hw_r         <= '0;
      pix_r        <= '0;
      lowb_r       <= 1'b0;
      x_r          <= '0;
      y_r          <= '0;
      w_r          <= '0;
      h_r          <= '0;
      r_r          <= '0;
      color_r      <= '0;
      max_r_r      <= MAX_RADIUS_RST;
      root_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      job_r        <= job_nxt;
      phase_r      <= phase_nxt;
      row_r        <= row_nxt;
      lower_r      <= lower_nxt;
      hw_r         <= hw_nxt;
      pix_r        <= pix_nxt;
      lowb_r       <= lowb_nxt;
      x_r          <= x_nxt;
      y_r          <= y_nxt;
      w_r          <= w_nxt;
      h_r          <= h_nxt;
      r_r          <= r_nxt;
      color_r      <= color_nxt;
      max_r_r      <= max_r_nxt;
      root_start_r <= root_start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.is_data  = out_data_r;
  assign out_chan.last     = out_last_r;

endmodule

/* dv/tb_lcd_rect_circle_fill_sequencer_core.sv */
// ---------------------------------------------------------------------------
// tb_lcd_rect_circle_fill_sequencer_core
// self-checking bench for the panel fill sequencer: a queue-fed driver sends
// rectangle, circle and advance requests with random pauses, a built-in
// predictor works out every panel byte, and a monitor with random stalls
// compares each byte, flag and end marker against the predicted stream
// ---------------------------------------------------------------------------
module tb_lcd_rect_circle_fill_sequencer_core
  import lrcf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int PIX_PHASE = 11;
  localparam int RAND_ITEMS = 660;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [6:0]  radius;
    logic [15:0] color;
  } fill_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } panel_byte_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [RADIUS_W-1:0] cfg_wdata;

  lrcf_in_if  req_if ();
  lrcf_out_if byte_if ();

  lcd_rect_circle_fill_sequencer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (byte_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  fill_req_t   pending_reqs[$];
  panel_byte_t expected_bytes[$];

  // predicted block state
  logic [6:0]  max_r = MAX_RADIUS_RST;
  job_t        job = JOB_IDLE;
  int          phase;
  logic [6:0]  row;
  logic        lower;
  logic [6:0]  half_w;
  logic [15:0] px_left;
  logic        low_next;
  logic [7:0]  lat_x, lat_y, lat_w, lat_h;
  logic [6:0]  lat_r;
  logic [15:0] lat_color;

  int errors, n_taken, n_checked, n_rects, n_circles, n_cfg;
  int plan_left, planned_items;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int span_half(int r, int i);
    int d;
    int c;
    d = 25 * (r * r - i * i);
    c = 1;
    while (c < 127 && (5 * (c + 1) - 2) * (5 * (c + 1) - 2) <= d)
      c++;
    return c;
  endfunction

  function automatic void open_row();
    half_w   = 7'(span_half(lat_r, row));
    lower    = 1'b0;
    phase    = 0;
    low_next = 1'b0;
    px_left  = {8'h00, half_w, 1'b0};
  endfunction

  function automatic bit close_window();
    if (job == JOB_CIRC) begin
      if (!lower) begin
        lower    = 1'b1;
        phase    = 0;
        low_next = 1'b0;
        px_left  = {8'h00, half_w, 1'b0};
        return 1'b0;
      end
      row = row + 7'd1;
      if (row < lat_r) begin
        open_row();
        return 1'b0;
      end
    end
    job   = JOB_IDLE;
    phase = 0;
    return 1'b1;
  endfunction

  task automatic predict_bytes(input fill_req_t r);
    logic [15:0] wx, wy, ww, wh, c1, c2, r2;
    panel_byte_t b;
    if (r.func == FUNC_RECT || r.func == FUNC_CIRC) begin
      if (job != JOB_IDLE)
        return;
      lat_x     = r.x;
      lat_y     = r.y;
      lat_color = r.color;
      if (r.func == FUNC_RECT) begin
        lat_w    = r.w;
        lat_h    = r.h;
        job      = JOB_RECT;
        phase    = 0;
        low_next = 1'b0;
        px_left  = 16'(lat_w) * 16'(lat_h);
        n_rects++;
      end else begin
        if (r.radius == 0 || r.radius > max_r)
          return;
        lat_r = r.radius;
        job   = JOB_CIRC;
        row   = '0;
        open_row();
        n_circles++;
      end
      return;
    end
    if (r.func != FUNC_ADV || job == JOB_IDLE)
      return;

    if (job == JOB_RECT) begin
      wx = 16'(lat_x);
      wy = 16'(lat_y);
      ww = 16'(lat_w);
      wh = 16'(lat_h);
    end else begin
      wx = {8'h00, lat_x} - {9'h000, half_w};
      wy = lower ? {8'h00, lat_y} + {9'h000, row} : {8'h00, lat_y} - {9'h000, row};
      ww = {8'h00, half_w, 1'b0};
      wh = 16'd1;
    end
    c1 = wx + 16'd1;
    c2 = wx + ww;
    r2 = wy + wh;
    b.is_data = 1'b1;
    b.last    = 1'b0;

    if (phase < PIX_PHASE) begin
      case (phase)
        0: begin
          b.value = CMD_CASET;
          b.is_data = 1'b0;
        end
        1: b.value = c1[15:8];
        2: b.value = c1[7:0];
        3: b.value = c2[15:8];
        4: b.value = c2[7:0];
        5: begin
          b.value = CMD_RASET;
          b.is_data = 1'b0;
        end
        6: b.value = wy[15:8];
        7: b.value = wy[7:0];
        8: b.value = r2[15:8];
        9: b.value = r2[7:0];
        default: begin
          b.value = CMD_RAMWR;
          b.is_data = 1'b0;
        end
      endcase
      phase++;
      if (phase == PIX_PHASE && px_left == 0)
        b.last = close_window();
    end else if (!low_next) begin
      b.value  = lat_color[15:8];
      low_next = 1'b1;
    end else begin
      b.value  = lat_color[7:0];
      low_next = 1'b0;
      px_left  = px_left - 16'd1;
      if (px_left == 0)
        b.last = close_window();
    end
    expected_bytes.push_back(b);
  endtask

  function automatic int pick_pause(bit quiet);
    int p;
    if (quiet)
      return 0;
    p = $urandom_range(0, 99);
    if (p < 55)
      return 0;
    if (p < 85)
      return $urandom_range(1, 3);
    if (p < 97)
      return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  // request driver
  fill_req_t cur_req;
  int        in_hold;
  bit        in_quiet;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      in_hold = 0;
    end else begin
      if ($urandom_range(0, 299) == 0)
        in_quiet = !in_quiet;
      if (req_if.valid && req_if.ready) begin
        predict_bytes(cur_req);
        n_taken++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (in_hold > 0) begin
          in_hold--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          req_if.func        <= cur_req.func;
          req_if.pos_x       <= cur_req.x;
          req_if.pos_y       <= cur_req.y;
          req_if.rect_width  <= cur_req.w;
          req_if.rect_height <= cur_req.h;
          req_if.radius      <= cur_req.radius;
          req_if.fill_color  <= cur_req.color;
          req_if.valid       <= 1'b1;
          in_hold = pick_pause(in_quiet);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor
  panel_byte_t exp_b;
  int          out_hold;
  bit          out_quiet;

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_if.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if ($urandom_range(0, 299) == 0)
        out_quiet = !out_quiet;
      if (byte_if.valid && byte_if.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte: actual %h is_data %b last %b", $time,
                   byte_if.out_byte, byte_if.is_data, byte_if.last);
          errors++;
        end else begin
          exp_b = expected_bytes.pop_front();
          n_checked++;
          if (byte_if.out_byte !== exp_b.value) begin
            $display("%0t: out_byte mismatch: expected %h actual %h", $time,
                     exp_b.value, byte_if.out_byte);
            errors++;
          end
          if (byte_if.is_data !== exp_b.is_data) begin
            $display("%0t: is_data mismatch: expected %b actual %b", $time,
                     exp_b.is_data, byte_if.is_data);
            errors++;
          end
          if (byte_if.last !== exp_b.last) begin
            $display("%0t: last mismatch: expected %b actual %b", $time,
                     exp_b.last, byte_if.last);
            errors++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        byte_if.ready <= 1'b0;
      end else begin
        byte_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          out_hold = pick_pause(out_quiet);
      end
    end
  end

  // stimulus planning
  task automatic add_req(input logic [1:0] f, input int x, input int y, input int w,
                         input int h, input int r, input int color);
    fill_req_t q;
    q.func   = f;
    q.x      = 8'(x);
    q.y      = 8'(y);
    q.w      = 8'(w);
    q.h      = 8'(h);
    q.radius = 7'(r);
    q.color  = 16'(color);
    pending_reqs.push_back(q);
  endtask

  task automatic plan_rect(input int x, input int y, input int w, input int h,
                           input int color);
    add_req(FUNC_RECT, x, y, w, h, $urandom, color);
    if (plan_left == 0) begin
      plan_left = 11 + 2 * w * h;
      planned_items++;
    end
  endtask

  task automatic plan_circle(input int x, input int y, input int r, input int color);
    int n;
    add_req(FUNC_CIRC, x, y, $urandom, $urandom, r, color);
    if (plan_left == 0 && r != 0 && r <= max_r) begin
      n = 0;
      for (int i = 0; i < r; i++)
        n += 2 * (11 + 4 * span_half(r, i));
      plan_left = n;
      planned_items++;
    end
  endtask

  task automatic plan_advance();
    add_req(FUNC_ADV, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (plan_left > 0) begin
      plan_left--;
      planned_items++;
    end
  endtask

  // only while a fill is running, so starts are dropped
  task automatic add_noise();
    logic [1:0] f;
    case ($urandom_range(0, 2))
      0: f = FUNC_RECT;
      1: f = FUNC_CIRC;
      default: f = FUNC_NONE;
    endcase
    add_req(f, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic plan_run_out();
    while (plan_left > 0) begin
      if ($urandom_range(0, 29) == 0)
        add_noise();
      plan_advance();
    end
  endtask

  task automatic random_job();
    int sel, w, h, lim, r;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(0, 255);
          h = 0;
        end
        1: begin
          w = 0;
          h = $urandom_range(0, 255);
        end
        default: begin
          w = $urandom_range(0, 3);
          h = $urandom_range(0, 3);
        end
      endcase
      plan_rect($urandom, $urandom, w, h, $urandom);
      plan_run_out();
    end else if (sel < 85) begin
      lim = ($urandom_range(0, 14) == 0) ? 6 : 2;
      if (max_r < lim)
        lim = max_r;
      r = (lim == 0) ? 0 : $urandom_range(1, lim);
      plan_circle($urandom, $urandom, r, $urandom);
      plan_run_out();
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          if (max_r == 127 || $urandom_range(0, 2) == 0)
            r = 0;
          else
            r = $urandom_range(max_r + 1, 127);
          plan_circle($urandom, $urandom, r, $urandom);
        end
        1: plan_advance();
        default: add_req(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
      endcase
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) plan_advance();
  endtask

  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_bytes.size() != 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_max_radius(input logic [6:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_r = v;
    n_cfg++;
  endtask

  initial begin
    logic [6:0] settings[6];
    int quota;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_if.valid        = 1'b0;
    req_if.func         = FUNC_ADV;
    req_if.pos_x        = '0;
    req_if.pos_y        = '0;
    req_if.rect_width   = '0;
    req_if.rect_height  = '0;
    req_if.radius       = '0;
    req_if.fill_color   = '0;
    byte_if.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    plan_advance();
    add_req(FUNC_NONE, 1, 2, 3, 4, 5, 6);
    plan_rect(0, 0, 0, 0, 16'h0000);
    plan_run_out();
    plan_rect(255, 255, 255, 0, $urandom);
    plan_run_out();
    plan_rect(17, 200, 0, 255, $urandom);
    plan_run_out();
    plan_rect(255, 0, 1, 1, 16'hffff);
    plan_advance();
    plan_circle(10, 10, 3, 16'h1234);
    add_req(FUNC_NONE, 0, 0, 0, 0, 0, 0);
    plan_rect(1, 1, 9, 9, 16'h0000);
    plan_run_out();
    plan_rect(3, 4, 2, 3, 16'h0000);
    plan_run_out();
    plan_circle(0, 0, 1, $urandom);
    plan_run_out();
    plan_circle(2, 255, 4, $urandom);
    plan_run_out();
    plan_circle(50, 50, 0, $urandom);
    plan_advance();
    wait_drained();

    write_max_radius(7'd1);
    plan_circle(60, 60, 2, $urandom);
    plan_circle(128, 128, 1, $urandom);
    plan_run_out();
    plan_circle(128, 128, 127, $urandom);
    wait_drained();

    write_max_radius(7'd0);
    plan_circle(5, 5, 1, $urandom);
    plan_advance();
    wait_drained();

    // random part over several radius limits
    settings = '{7'd127, 7'd0, 7'd2, 7'd5, 7'($urandom_range(0, 127)), 7'd127};
    foreach (settings[k]) begin
      write_max_radius(settings[k]);
      quota = planned_items + RAND_ITEMS / 6;
      while (planned_items < quota)
        random_job();
      wait_drained();
    end

    $display("run covered %0d requests taken, %0d panel bytes checked", n_taken, n_checked);
    $display("fills started: %0d rectangles, %0d circles; max_radius writes: %0d",
             n_rects, n_circles, n_cfg);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #8ms;
    $display("Verification failed");
    $finish;
  end

endmodule

/* lcd_rect_circle_fill_sequencer_core.f */
hdl/lrcf_pkg.sv
hdl/lrcf_if.sv
hdl/lrcf_root_unit.sv
hdl/lcd_rect_circle_fill_sequencer_core.sv
dv/tb_lcd_rect_circle_fill_sequencer_core.sv
